/* rtl/core/ipc_pkg.sv */
// ipc_pkg: shared types and opcode constants for the instruction pair classifier
package ipc_pkg;

   localparam int unsigned KIND_W = 14;
   localparam int unsigned REG_W  = 5;

   // kind code form bits
   localparam int unsigned FORM_OP4_BIT = 12;
   localparam int unsigned FORM_ESC_BIT = 13;

   // op6 codes
   localparam logic [5:0] OP6_ESCAPE    = 6'h3F;
   localparam logic [5:0] OP6_IMM5_LO   = 6'h10;
   localparam logic [5:0] OP6_IMM5_HI   = 6'h17;
   localparam logic [5:0] OP6_ARITH_LO  = 6'h30;
   localparam logic [5:0] OP6_ARITH_HI  = 6'h37;
   localparam logic [5:0] OP6_MEM_LO    = 6'h38;
   localparam logic [5:0] OP6_MEM_HI    = 6'h3B;
   localparam logic [5:0] OP6_ST_DISP_A = 6'h3A;
   localparam logic [5:0] OP6_ST_DISP_B = 6'h3B;

   // op4 codes
   localparam logic [3:0] OP4_SHORT_LO = 4'h6;
   localparam logic [3:0] OP4_LOAD_A   = 4'h6;
   localparam logic [3:0] OP4_LOAD_B   = 4'h8;
   localparam logic [3:0] OP4_LDST     = 4'hA;
   localparam logic [3:0] OP4_BRANCH   = 4'hB;

   typedef struct packed {
      logic [KIND_W-1:0] kind_code;
      logic [REG_W-1:0]  dest_reg;
      logic              src1_valid;
      logic [REG_W-1:0]  src1_reg;
      logic              src2_valid;
      logic [REG_W-1:0]  src2_reg;
      logic              is_memory;
      logic              is_arith;
   } decode_type;

endpackage

/* rtl/core/ipc_decode.sv */
// ipc_decode: combinational decode of one instruction word into class fields
module ipc_decode
   import ipc_pkg::*;
(
   input  logic [31:0] insn_word,
   output decode_type  result
);

   logic [15:0] half;
   logic [5:0]  op6;
   logic [3:0]  op4;
   logic [4:0]  reg1;
   logic [4:0]  reg2;
   logic [4:0]  sub_op;
   logic        short_form;
   logic        short_load;
   logic        escape;
   logic        imm5_form;
   logic [KIND_W-1:0] kind;

   assign half   = insn_word[15:0];
   assign op6    = half[10:5];
   assign op4    = half[10:7];
   assign reg1   = half[4:0];
   assign reg2   = half[15:11];
   assign sub_op = insn_word[20:16];

   assign short_form = (op4 >= OP4_SHORT_LO) && (op4 <= OP4_BRANCH);
   assign short_load = (op4 == OP4_LOAD_A) || (op4 == OP4_LOAD_B) ||
                       ((op4 == OP4_LDST) && !half[0]);
   assign escape     = !short_form && (op6 == OP6_ESCAPE);
   assign imm5_form  = (op6 >= OP6_IMM5_LO) && (op6 <= OP6_IMM5_HI);

   always_comb begin
      kind = '0;
      if (short_form) begin
         kind[FORM_OP4_BIT] = 1'b1;
         kind[8:5]          = op4;
         if (op4 == OP4_BRANCH) begin
            kind[3:0] = half[3:0];
         end else if (op4 == OP4_LDST) begin
            kind[0] = half[0];
         end
      end else if (escape) begin
         kind[FORM_ESC_BIT] = 1'b1;
         kind[10:6]         = sub_op;
         kind[5:0]          = OP6_ESCAPE;
      end else begin
         kind[5:0] = op6;
      end
   end

   always_comb begin
      result           = '0;
      result.kind_code = kind;

      if (short_form) begin
         result.dest_reg = short_load ? reg2 : '0;
      end else if ((op6 == OP6_ST_DISP_A) || (op6 == OP6_ST_DISP_B)) begin
         result.dest_reg = '0;
      end else begin
         result.dest_reg = reg2;
      end

      result.src1_valid = !(short_form || imm5_form);
      result.src1_reg   = result.src1_valid ? reg1 : '0;

      if (short_form) begin
         result.src2_valid = !short_load;
      end else begin
         result.src2_valid = (op6 <= OP6_IMM5_HI) ||
                             ((op6 >= OP6_MEM_LO) && (op6 <= OP6_MEM_HI));
      end
      result.src2_reg = result.src2_valid ? reg2 : '0;

      // op6 memory range never overlaps the op4 short forms
      result.is_memory = (short_form && (op4 <= OP4_LDST)) ||
                         ((op6 >= OP6_MEM_LO) && (op6 <= OP6_MEM_HI));
      result.is_arith  = (op6 <= OP6_IMM5_HI) ||
                         ((op6 >= OP6_ARITH_LO) && (op6 <= OP6_ARITH_HI));
   end

endmodule

/* rtl/core/instruction_pair_classifier_unit.sv */
// instruction_pair_classifier_unit: registered decoder of 32-bit instruction words
//
// req channel: one 32-bit instruction word per transaction (req_valid/req_ready).
// rsp channel: kind code, destination register, two source registers with valid
// flags and the memory / arithmetic class flags (rsp_valid/rsp_ready).
// Each word is captured in an input register, decoded by a short combinational
// path and lands in the result register.
// Throughput is one transaction per cycle while rsp_ready stays high; the rate
// is set by the two-register pipeline, each stage moving once per cycle.
// When the receiver stalls, the result register holds its transaction and the
// input register can still take one more word; req_ready drops only once both
// stages are full.
// Synchronous reset empties both stages; no transaction is presented until a
// new word is accepted after reset. Payload registers are not reset.
module instruction_pair_classifier_unit
   import ipc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_insn_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_kind_code,
   output logic [REG_W-1:0]  rsp_dest_reg,
   output logic              rsp_src1_valid,
   output logic [REG_W-1:0]  rsp_src1_reg,
   output logic              rsp_src2_valid,
   output logic [REG_W-1:0]  rsp_src2_reg,
   output logic              rsp_is_memory,
   output logic              rsp_is_arith
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [31:0] word_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   decode_type  result_ff;
   decode_type  decoded;
   logic        out_advance;
   logic        in_take;

   ipc_decode u_decode (
      .insn_word (word_ff),
      .result    (decoded)
   );

   // result stage may load when empty or when its transaction leaves this cycle
   assign out_advance = !out_valid_ff || rsp_ready;
   assign req_ready   = !in_valid_ff || out_advance;
   assign in_take     = req_valid && req_ready;

   assign in_valid_in  = in_take || (in_valid_ff && !out_advance);
   assign out_valid_in = out_advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         word_ff <= req_insn_word;
      end
      if (out_advance && in_valid_ff) begin
         result_ff <= decoded;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind_code  = result_ff.kind_code;
   assign rsp_dest_reg   = result_ff.dest_reg;
   assign rsp_src1_valid = result_ff.src1_valid;
   assign rsp_src1_reg   = result_ff.src1_reg;
   assign rsp_src2_valid = result_ff.src2_valid;
   assign rsp_src2_reg   = result_ff.src2_reg;
   assign rsp_is_memory  = result_ff.is_memory;
   assign rsp_is_arith   = result_ff.is_arith;

endmodule

/* rtl/core/ipc_checker.sv */
// ipc_checker: port-level assertions for the instruction pair classifier, with bind
module ipc_checker
   import ipc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [KIND_W-1:0] rsp_kind_code,
   input logic [REG_W-1:0]  rsp_dest_reg,
   input logic              rsp_src1_valid,
   input logic [REG_W-1:0]  rsp_src1_reg,
   input logic              rsp_src2_valid,
   input logic [REG_W-1:0]  rsp_src2_reg,
   input logic              rsp_is_memory,
   input logic              rsp_is_arith
);

   // a stalled transaction stays presented
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind_code) && $stable(rsp_dest_reg) &&
         $stable(rsp_src1_valid) && $stable(rsp_src1_reg) &&
         $stable(rsp_src2_valid) && $stable(rsp_src2_reg) &&
         $stable(rsp_is_memory) && $stable(rsp_is_arith))
      else $error("rsp payload changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // an invalid source always reads as register zero
   a_src_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_src1_valid || rsp_src1_reg == '0) &&
                    (rsp_src2_valid || rsp_src2_reg == '0))
      else $error("invalid source carries a register number");

   // op4 forms never read reg1 and are never arithmetic
   a_op4_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind_code[FORM_OP4_BIT] |-> !rsp_src1_valid && !rsp_is_arith)
      else $error("op4 form decoded with reg1 source or arithmetic class");

endmodule

bind instruction_pair_classifier_unit ipc_checker u_ipc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind_code  (rsp_kind_code),
   .rsp_dest_reg   (rsp_dest_reg),
   .rsp_src1_valid (rsp_src1_valid),
   .rsp_src1_reg   (rsp_src1_reg),
   .rsp_src2_valid (rsp_src2_valid),
   .rsp_src2_reg   (rsp_src2_reg),
   .rsp_is_memory  (rsp_is_memory),
   .rsp_is_arith   (rsp_is_arith)
);

/* tb/tb_instruction_pair_classifier_unit.sv */
// tb_instruction_pair_classifier_unit: self-checking testbench of the instruction pair classifier
`timescale 1ns / 100ps

module tb_instruction_pair_classifier_unit;
   import ipc_pkg::*;

   // op6 / op4 codes without a package name, used only to build stimulus
   localparam logic [5:0] OP6_REG_FIRST = 6'h00;
   localparam logic [5:0] OP6_PLAIN_A   = 6'h3C;
   localparam logic [5:0] OP6_PLAIN_B   = 6'h3E;
   localparam logic [3:0] OP4_STORE_A   = 4'h7;
   localparam logic [3:0] OP4_STORE_B   = 4'h9;

   localparam int unsigned PHASE_WORDS = 600;

   class decode_board;
      decode_type  expected_q[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      function decode_type classify_word(logic [31:0] word);
         decode_type d;
         logic [15:0] h;
         logic [5:0]  op6;
         logic [3:0]  op4;
         logic [4:0]  r1;
         logic [4:0]  r2;
         logic        short_fmt;
         logic        short_ld;
         logic        esc;
         h         = word[15:0];
         op6       = h[10:5];
         op4       = h[10:7];
         r1        = h[4:0];
         r2        = h[15:11];
         short_fmt = (op4 >= OP4_SHORT_LO) && (op4 <= OP4_BRANCH);
         short_ld  = (op4 == OP4_LOAD_A) || (op4 == OP4_LOAD_B) ||
                     ((op4 == OP4_LDST) && !h[0]);
         esc       = !short_fmt && (op6 == OP6_ESCAPE);
         d = '0;
         if (short_fmt) begin
            d.kind_code[FORM_OP4_BIT] = 1'b1;
            d.kind_code[8:5] = op4;
            if (op4 == OP4_BRANCH) d.kind_code[3:0] = h[3:0];
            else if (op4 == OP4_LDST) d.kind_code[0] = h[0];
         end else if (esc) begin
            d.kind_code[FORM_ESC_BIT] = 1'b1;
            d.kind_code[10:6] = word[20:16];
            d.kind_code[5:0]  = op6;
         end else begin
            d.kind_code[5:0] = op6;
         end
         if (short_fmt) d.dest_reg = short_ld ? r2 : '0;
         else if (op6 == OP6_ST_DISP_A || op6 == OP6_ST_DISP_B) d.dest_reg = '0;
         else d.dest_reg = r2;
         // imm5 arithmetic carries an immediate in the reg1 field
         if (!(short_fmt || (op6 >= OP6_IMM5_LO && op6 <= OP6_IMM5_HI))) begin
            d.src1_valid = 1'b1;
            d.src1_reg   = r1;
         end
         if (short_fmt) d.src2_valid = !short_ld;
         else d.src2_valid = (op6 <= OP6_IMM5_HI) || (op6 >= OP6_MEM_LO && op6 <= OP6_MEM_HI);
         if (d.src2_valid) d.src2_reg = r2;
         d.is_memory = short_fmt ? (op4 <= OP4_LDST) :
                       (!esc && op6 >= OP6_MEM_LO && op6 <= OP6_MEM_HI);
         d.is_arith  = !short_fmt && !esc &&
                       ((op6 <= OP6_IMM5_HI) || (op6 >= OP6_ARITH_LO && op6 <= OP6_ARITH_HI));
         return d;
      endfunction

      function void note_word(logic [31:0] word);
         expected_q.push_back(classify_word(word));
      endfunction

      function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
         if (exp_val != act_val) begin
            $error("%s mismatch: expected 0x%0h actual 0x%0h", name, exp_val, act_val);
            mismatches++;
         end
      endfunction

      function void check_result(decode_type got);
         decode_type exp_d;
         if (expected_q.size() == 0) begin
            $error("result transaction with nothing expected: kind_code 0x%0h", got.kind_code);
            mismatches++;
            return;
         end
         exp_d = expected_q.pop_front();
         compare_field("kind_code", exp_d.kind_code, got.kind_code);
         compare_field("dest_reg", exp_d.dest_reg, got.dest_reg);
         compare_field("src1_valid", exp_d.src1_valid, got.src1_valid);
         compare_field("src1_reg", exp_d.src1_reg, got.src1_reg);
         compare_field("src2_valid", exp_d.src2_valid, got.src2_valid);
         compare_field("src2_reg", exp_d.src2_reg, got.src2_reg);
         compare_field("is_memory", exp_d.is_memory, got.is_memory);
         compare_field("is_arith", exp_d.is_arith, got.is_arith);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [31:0]       req_insn_word;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [KIND_W-1:0] rsp_kind_code;
   logic [REG_W-1:0]  rsp_dest_reg;
   logic              rsp_src1_valid;
   logic [REG_W-1:0]  rsp_src1_reg;
   logic              rsp_src2_valid;
   logic [REG_W-1:0]  rsp_src2_reg;
   logic              rsp_is_memory;
   logic              rsp_is_arith;

   decode_board board;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   instruction_pair_classifier_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_insn_word  (req_insn_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind_code  (rsp_kind_code),
      .rsp_dest_reg   (rsp_dest_reg),
      .rsp_src1_valid (rsp_src1_valid),
      .rsp_src1_reg   (rsp_src1_reg),
      .rsp_src2_valid (rsp_src2_valid),
      .rsp_src2_reg   (rsp_src2_reg),
      .rsp_is_memory  (rsp_is_memory),
      .rsp_is_arith   (rsp_is_arith)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] make_word(logic [15:0] upper, logic [4:0] r2,
                                             logic [5:0] op6, logic [4:0] r1);
      return {upper, r2, op6, r1};
   endfunction

   // called at a rising edge; returns at the edge that accepts the transaction
   task automatic send_word(logic [31:0] word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_insn_word <= word;
      do @(posedge clock); while (!req_ready);
      board.note_word(word);
   endtask

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 7))
         0: w[10:5] = OP6_ESCAPE;
         1: w[10:5] = {OP4_SHORT_LO + 4'($urandom_range(0, 5)), 2'($urandom_range(0, 3))};
         2: w[10:5] = 6'($urandom_range(OP6_ARITH_LO, OP6_ESCAPE));
         default: ;
      endcase
      return w;
   endfunction

   // result side: check on the accepting edge, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result('{kind_code: rsp_kind_code, dest_reg: rsp_dest_reg,
                              src1_valid: rsp_src1_valid, src1_reg: rsp_src1_reg,
                              src2_valid: rsp_src2_valid, src2_reg: rsp_src2_reg,
                              is_memory: rsp_is_memory, is_arith: rsp_is_arith});
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   initial begin
      logic [31:0] directed_words[$];
      board         = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_insn_word = '0;
      rsp_ready     = 1'b0;
      send_idle_pct = 35;
      recv_idle_pct = 79;

      directed_words = '{
         32'h0000_0000,
         32'hFFFF_FFFF,
         make_word(16'h0000, 5'd31, OP6_REG_FIRST, 5'd31),
         make_word(16'h0000, 5'd3, OP6_IMM5_LO, 5'h15),
         make_word(16'h0000, 5'd31, OP6_IMM5_HI, 5'd31),
         make_word(16'h0000, 5'd7, {OP4_LOAD_A, 2'b00}, 5'd9),
         make_word(16'h1234, 5'd31, {OP4_STORE_A, 2'b11}, 5'd31),
         make_word(16'h0000, 5'd12, {OP4_LOAD_B, 2'b01}, 5'd1),
         make_word(16'h0000, 5'd30, {OP4_STORE_B, 2'b10}, 5'd0),
         make_word(16'h0000, 5'd17, {OP4_LDST, 2'b00}, 5'h1E),
         make_word(16'hFFFF, 5'd17, {OP4_LDST, 2'b11}, 5'h01),
         make_word(16'h0000, 5'd5, {OP4_BRANCH, 2'b00}, 5'h10),
         make_word(16'h0000, 5'd31, {OP4_BRANCH, 2'b11}, 5'h0F),
         make_word(16'h0000, 5'd1, OP6_ARITH_LO, 5'd2),
         make_word(16'h0000, 5'd31, OP6_ARITH_HI, 5'd0),
         make_word(16'h0000, 5'd4, OP6_MEM_LO, 5'd8),
         make_word(16'h0000, 5'd4, OP6_MEM_LO + 6'd1, 5'd8),
         make_word(16'h0000, 5'd22, OP6_ST_DISP_A, 5'd11),
         make_word(16'h0000, 5'd23, OP6_ST_DISP_B, 5'd29),
         make_word(16'h0000, 5'd9, OP6_PLAIN_A, 5'd9),
         make_word(16'h0000, 5'd10, OP6_PLAIN_B, 5'd21),
         make_word(16'hFFE0, 5'd6, OP6_ESCAPE, 5'd14),
         make_word(16'h0015, 5'd0, OP6_ESCAPE, 5'd0),
         make_word(16'hFFFF, 5'd13, 6'h05, 5'd27),
         make_word(16'hA5A5, 5'd0, 6'h14, 5'd31)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_words[i]) send_word(directed_words[i]);

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin send_idle_pct = 35; recv_idle_pct = 79; end
            1: begin send_idle_pct = 79; recv_idle_pct = 35; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         repeat (PHASE_WORDS) send_word(random_word());
      end
      req_valid <= 1'b0;

      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      if (board.mismatches == 0) begin
         $display("tb_instruction_pair_classifier_unit passed");
      end else begin
         $display("tb_instruction_pair_classifier_unit failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("tb_instruction_pair_classifier_unit failed");
      $finish;
   end

endmodule
